[sv/fbo_pkg.sv]
// ----------------------------------------------------------------------------
// fbo_pkg
// Shared types and constants for the face-box overlay control block.
// ----------------------------------------------------------------------------
package fbo_pkg;

    // Widest coordinate held after clipping (image sides up to 4096 pixels).
    localparam int COORD_W  = 12;
    localparam int POS_W    = 16;
    localparam int TIME_W   = 32;
    localparam int TMO_W    = 16;
    localparam int OFF_W    = 19;
    localparam int LEN_W    = 10;
    localparam int ALPHA_W  = 8;

    localparam logic [ALPHA_W-1:0] ALPHA_DRAW  = 8'hFF;
    localparam logic [ALPHA_W-1:0] ALPHA_CLEAR = 8'h00;
    localparam logic [TMO_W-1:0]   TIMEOUT_RESET = 16'd200;
    localparam int                 MIN_EXTENT = 2;

    typedef enum logic {
        OP_REPORT  = 1'b0,
        OP_TIMEOUT = 1'b1
    } t_op;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
    } t_box;

    // One queued command: an optional clear of the old box, then an optional draw.
    typedef struct packed {
        logic has_clear;
        t_box clear_box;
        logic has_draw;
        t_box draw_box;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

[sv/fbo_front.sv]
// ----------------------------------------------------------------------------
// fbo_front
// Accepts reports and timeout checks, validates and clips boxes, keeps the
// shown box and its time, and queues the clear and draw commands.
// ----------------------------------------------------------------------------
module fbo_front #(
    parameter int IMG_WIDTH  = 640,
    parameter int IMG_HEIGHT = 480
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fbo_pkg::TMO_W-1:0]      i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_operation,
    input  logic [fbo_pkg::TIME_W-1:0]     i_time_ms,
    input  logic signed [fbo_pkg::POS_W-1:0] i_corner_a_x,
    input  logic signed [fbo_pkg::POS_W-1:0] i_corner_a_y,
    input  logic signed [fbo_pkg::POS_W-1:0] i_corner_b_x,
    input  logic signed [fbo_pkg::POS_W-1:0] i_corner_b_y,
    input  fbo_pkg::t_q_stat               i_q_stat,
    output logic                           o_push,
    output fbo_pkg::t_entry                o_entry
);
    import fbo_pkg::*;

    localparam logic signed [POS_W:0] W_S   = (POS_W+1)'(IMG_WIDTH);
    localparam logic signed [POS_W:0] H_S   = (POS_W+1)'(IMG_HEIGHT);
    localparam logic signed [POS_W:0] EXT_S = (POS_W+1)'(MIN_EXTENT);
    localparam logic [COORD_W-1:0]    W_MAX = COORD_W'(IMG_WIDTH - 1);
    localparam logic [COORD_W-1:0]    H_MAX = COORD_W'(IMG_HEIGHT - 1);

    logic [TMO_W-1:0]  r_timeout;
    logic              r_shown;
    t_box              r_box;
    logic [TIME_W-1:0] r_since;

    logic signed [POS_W:0] l, t, r, b;
    logic                  box_ok;
    t_box                  new_box;
    logic [TIME_W-1:0]     age;
    logic                  expired;
    logic                  accept;

    always_comb begin
        l = (i_corner_b_x < i_corner_a_x) ? (POS_W+1)'(i_corner_b_x)
                                          : (POS_W+1)'(i_corner_a_x);
        r = (i_corner_b_x < i_corner_a_x) ? (POS_W+1)'(i_corner_a_x)
                                          : (POS_W+1)'(i_corner_b_x);
        t = (i_corner_b_y < i_corner_a_y) ? (POS_W+1)'(i_corner_b_y)
                                          : (POS_W+1)'(i_corner_a_y);
        b = (i_corner_b_y < i_corner_a_y) ? (POS_W+1)'(i_corner_a_y)
                                          : (POS_W+1)'(i_corner_b_y);
        box_ok = !l[POS_W] && !t[POS_W] && (r <= W_S) && (b <= H_S)
                 && ((r - l) > EXT_S) && ((b - t) > EXT_S);
        // A valid box only ever overhangs by the border column or row itself.
        new_box.left   = l[COORD_W-1:0];
        new_box.top    = t[COORD_W-1:0];
        new_box.right  = (r >= W_S) ? W_MAX : r[COORD_W-1:0];
        new_box.bottom = (b >= H_S) ? H_MAX : b[COORD_W-1:0];
    end

    assign age     = i_time_ms - r_since;
    assign expired = r_shown && (age > {{(TIME_W-TMO_W){1'b0}}, r_timeout});

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        o_entry.draw_box  = new_box;
        o_entry.clear_box = r_box;
        if (t_op'(i_operation) == OP_REPORT) begin
            o_entry.has_clear = r_shown;
            o_entry.has_draw  = box_ok;
        end else begin
            o_entry.has_clear = expired;
            o_entry.has_draw  = 1'b0;
        end
        o_push = accept && (o_entry.has_clear || o_entry.has_draw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_shown   <= 1'b0;
            r_box     <= '0;
            r_since   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (accept) begin
                if (t_op'(i_operation) == OP_REPORT) begin
                    if (box_ok) begin
                        r_box   <= new_box;
                        r_since <= i_time_ms;
                    end
                    r_shown <= box_ok;
                end else if (expired) begin
                    r_shown <= 1'b0;
                end
            end
        end
    end

endmodule

[sv/fbo_queue.sv]
// ----------------------------------------------------------------------------
// fbo_queue
// Two-entry command queue between the front and the span sequencer.
// ----------------------------------------------------------------------------
module fbo_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fbo_pkg::t_entry  i_entry,
    input  logic             i_pop,
    output fbo_pkg::t_entry  o_entry,
    output fbo_pkg::t_q_stat o_stat
);
    import fbo_pkg::*;

    t_entry     r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_entry      = r_mem[r_rptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

[sv/fbo_back.sv]
// ----------------------------------------------------------------------------
// fbo_back
// Span sequencer: turns each queued command into up to eight line spans,
// one per cycle while i_ready does not stall it, into a registered output stage.
// ----------------------------------------------------------------------------
module fbo_back #(
    parameter int IMG_WIDTH = 640
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fbo_pkg::t_entry               i_entry,
    input  fbo_pkg::t_q_stat              i_q_stat,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [fbo_pkg::OFF_W-1:0]     o_start_offset,
    output logic                          o_is_vertical,
    output logic [fbo_pkg::LEN_W-1:0]     o_span_length,
    output logic [fbo_pkg::ALPHA_W-1:0]   o_alpha_value,
    output logic                          o_last_of_run
);
    import fbo_pkg::*;

    logic         r_busy;
    t_entry       r_ent;
    logic [2:0]   r_idx;

    logic               r_o_valid;
    logic [OFF_W-1:0]   r_off;
    logic               r_vert;
    logic [LEN_W-1:0]   r_len;
    logic [ALPHA_W-1:0] r_alpha;
    logic               r_last;

    logic               adv;
    logic               span_last;
    t_box               box;
    logic [COORD_W-1:0] row, col;
    logic [COORD_W:0]   len;
    logic               vert;
    logic [31:0]        off;
    logic [2:0]         n_idx;

    assign adv       = r_busy && (!r_o_valid || i_ready);
    assign span_last = (r_idx == 3'd7) || ((r_idx == 3'd3) && !r_ent.has_draw);
    assign o_pop     = !i_q_stat.empty && (!r_busy || (adv && span_last));
    assign n_idx     = i_entry.has_clear ? 3'd0 : 3'd4;

    // Lower half of the index walks the clear box, upper half the draw box.
    // Order within a box: top row, bottom row, left column, right column.
    always_comb begin
        box = r_idx[2] ? r_ent.draw_box : r_ent.clear_box;
        case (r_idx[1:0])
            2'd0: begin
                row = box.top;    col = box.left;  vert = 1'b0;
                len = {1'b0, box.right} - {1'b0, box.left} + 1'b1;
            end
            2'd1: begin
                row = box.bottom; col = box.left;  vert = 1'b0;
                len = {1'b0, box.right} - {1'b0, box.left} + 1'b1;
            end
            2'd2: begin
                row = box.top;    col = box.left;  vert = 1'b1;
                len = {1'b0, box.bottom} - {1'b0, box.top} + 1'b1;
            end
            default: begin
                row = box.top;    col = box.right; vert = 1'b1;
                len = {1'b0, box.bottom} - {1'b0, box.top} + 1'b1;
            end
        endcase
        off = 32'(row) * 32'(IMG_WIDTH) + 32'(col);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_entry;
        end
        if (adv) begin
            r_off   <= off[OFF_W-1:0];
            r_vert  <= vert;
            r_len   <= len[LEN_W-1:0];
            r_alpha <= r_idx[2] ? ALPHA_DRAW : ALPHA_CLEAR;
            r_last  <= span_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_idx     <= 3'd0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= n_idx;
            end else if (adv && span_last) begin
                r_busy <= 1'b0;
            end else if (adv) begin
                r_idx <= r_idx + 3'd1;
            end
            if (adv) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_o_valid;
    assign o_start_offset = r_off;
    assign o_is_vertical  = r_vert;
    assign o_span_length  = r_len;
    assign o_alpha_value  = r_alpha;
    assign o_last_of_run  = r_last;

endmodule

[sv/face_box_overlay_control.sv]
// ----------------------------------------------------------------------------
// face_box_overlay_control
// Face-box overlay control: turns box reports and timeout checks into
// alpha-buffer line spans that clear the old box and draw the new one.
// ----------------------------------------------------------------------------
// The front takes one item per cycle while its two-entry command queue has
// room; an item that changes nothing on screen is accepted and queues no
// command. Each report or timeout check produces zero, four or eight spans,
// and the span sequencer emits one span per cycle while i_ready allows, so
// a report that replaces a shown box yields eight spans and a first draw or
// a clear four; the sequencer sets the sustained rate, one span per cycle.
// Spans of one item arrive in order: clear of the old box (top row, bottom
// row, left column, right column), then the draw of the new box, and the
// final span of each item carries last_of_run.
module face_box_overlay_control #(
    parameter int IMG_WIDTH  = 640,
    parameter int IMG_HEIGHT = 480
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fbo_pkg::TMO_W-1:0]        i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_operation,
    input  logic [fbo_pkg::TIME_W-1:0]       i_time_ms,
    input  logic signed [fbo_pkg::POS_W-1:0] i_corner_a_x,
    input  logic signed [fbo_pkg::POS_W-1:0] i_corner_a_y,
    input  logic signed [fbo_pkg::POS_W-1:0] i_corner_b_x,
    input  logic signed [fbo_pkg::POS_W-1:0] i_corner_b_y,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [fbo_pkg::OFF_W-1:0]        o_start_offset,
    output logic                             o_is_vertical,
    output logic [fbo_pkg::LEN_W-1:0]        o_span_length,
    output logic [fbo_pkg::ALPHA_W-1:0]      o_alpha_value,
    output logic                             o_last_of_run
);
    import fbo_pkg::*;

    logic    q_push;
    logic    q_pop;
    t_entry  push_entry;
    t_entry  head_entry;
    t_q_stat q_stat;

    fbo_front #(
        .IMG_WIDTH (IMG_WIDTH),
        .IMG_HEIGHT(IMG_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_time_ms   (i_time_ms),
        .i_corner_a_x(i_corner_a_x),
        .i_corner_a_y(i_corner_a_y),
        .i_corner_b_x(i_corner_b_x),
        .i_corner_b_y(i_corner_b_y),
        .i_q_stat    (q_stat),
        .o_push      (q_push),
        .o_entry     (push_entry)
    );

    fbo_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_entry(push_entry),
        .i_pop  (q_pop),
        .o_entry(head_entry),
        .o_stat (q_stat)
    );

    fbo_back #(
        .IMG_WIDTH(IMG_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (head_entry),
        .i_q_stat      (q_stat),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_start_offset(o_start_offset),
        .o_is_vertical (o_is_vertical),
        .o_span_length (o_span_length),
        .o_alpha_value (o_alpha_value),
        .o_last_of_run (o_last_of_run)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("command queue read while empty");

    a_alpha_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_alpha_value == ALPHA_DRAW || o_alpha_value == ALPHA_CLEAR))
        else $error("span carries an alpha that is neither draw nor clear");

endmodule
